/* hdl/message_id_dedup_ring_unit_macros.svh */
// assertion helpers shared by the ring sequencer
`ifndef MESSAGE_ID_DEDUP_RING_UNIT_MACROS_SVH
`define MESSAGE_ID_DEDUP_RING_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define MDR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MDR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mdr_pkg.sv */
package mdr_pkg;

  localparam int unsigned ID_W   = 32;
  localparam int unsigned SLOT_W = 5;

  typedef enum logic [0:0] {
    S_IDLE,
    S_SCAN
  } seq_state_t;

  typedef enum logic [0:0] {
    REQ_LOOKUP = 1'b0,
    REQ_INSERT = 1'b1
  } req_type_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

/* hdl/mdr_store.sv */
module mdr_store import mdr_pkg::*; #(
  parameter int unsigned RING_DEPTH = 32,
  parameter int unsigned IDX_W      = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mem_ctl_t          ctl,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [ID_W-1:0]   wr_id,
  input  logic              wr_flag,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [ID_W-1:0]   rd_id,
  output logic              rd_flag
);

  logic [ID_W-1:0]       id_mem [RING_DEPTH];
  logic                  flag_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid_r;
  logic [ID_W-1:0]       rd_id_r;
  logic                  rd_flag_r;
  logic                  rd_valid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      id_mem[wr_addr]   <= wr_id;
      flag_mem[wr_addr] <= wr_flag;
    end
    if (ctl.rd_en) begin
      rd_id_r   <= id_mem[rd_addr];
      rd_flag_r <= flag_mem[rd_addr];
    end
  end

  // entries not yet written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_id   = rd_valid_r ? rd_id_r : '0;
  assign rd_flag = rd_valid_r & rd_flag_r;

endmodule

/* hdl/mdr_seq.sv */
`include "message_id_dedup_ring_unit_macros.svh"

module mdr_seq import mdr_pkg::*; #(
  parameter int unsigned RING_DEPTH = 32,
  parameter int unsigned IDX_W      = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [ID_W-1:0]   message_id,
  input  logic              server_flag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              match_found,
  output logic [SLOT_W-1:0] slot_index,
  output logic              server_hit,
  output mem_ctl_t          ctl,
  output logic [IDX_W-1:0]  wr_addr,
  output logic [ID_W-1:0]   wr_id,
  output logic              wr_flag,
  output logic [IDX_W-1:0]  rd_addr,
  input  logic [ID_W-1:0]   rd_id,
  input  logic              rd_flag
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  seq_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  wp_r, wp_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [ID_W-1:0]   key_r, key_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              match_r, match_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              hit_r, hit_nxt;
  logic              accept;
  logic              id_eq;

  // the one comparator, reused for every slot of a scan
  assign id_eq = (rd_id == key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      cmp_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    match_r <= match_nxt;
    slot_r  <= slot_nxt;
    hit_r   <= hit_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    cmp_idx_nxt   = cmp_idx_r;
    key_nxt       = key_r;
    match_nxt     = match_r;
    slot_nxt      = slot_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    ctl           = '0;
    rd_addr       = '0;
    in_ready      = (state_r == S_IDLE) & (~out_valid_r | out_ready);
    accept        = in_valid & in_ready;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (req_type == REQ_INSERT) begin
            ctl.wr_en     = 1'b1;
            match_nxt     = 1'b0;
            slot_nxt      = SLOT_W'(wp_r);
            hit_nxt       = 1'b0;
            out_valid_nxt = 1'b1;
            wp_nxt        = (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
          end else begin
            ctl.rd_en   = 1'b1;
            rd_addr     = '0;
            key_nxt     = message_id;
            cmp_idx_nxt = '0;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // read data on this cycle belongs to slot cmp_idx_r
        if (id_eq) begin
          match_nxt     = 1'b1;
          slot_nxt      = SLOT_W'(cmp_idx_r);
          hit_nxt       = rd_flag;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (cmp_idx_r == LAST_IDX) begin
          match_nxt     = 1'b0;
          slot_nxt      = '0;
          hit_nxt       = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ctl.rd_en   = 1'b1;
          rd_addr     = cmp_idx_r + 1'b1;
          cmp_idx_nxt = cmp_idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign wr_addr     = wp_r;
  assign wr_id       = message_id;
  assign wr_flag     = server_flag;
  assign out_valid   = out_valid_r;
  assign match_found = match_r;
  assign slot_index  = slot_r;
  assign server_hit  = hit_r;

  `MDR_ASSERT_NXT(a_insert_result, clk, rst_n, accept && req_type == REQ_INSERT, out_valid_r && !match_r && !hit_r, "insert must give a non-match result next cycle")
  `MDR_ASSERT_IMP(a_scan_out_empty, clk, rst_n, state_r == S_SCAN, !out_valid_r, "result register busy during a scan")
  `MDR_ASSERT_IMP(a_scan_idx_range, clk, rst_n, state_r == S_SCAN, cmp_idx_r <= LAST_IDX, "scan index beyond ring")
  `MDR_ASSERT_IMP(a_wp_range, clk, rst_n, 1'b1, wp_r <= LAST_IDX, "write pointer beyond ring")

endmodule

/* hdl/message_id_dedup_ring_unit.sv */
// insert: result registered in the cycle after the beat is accepted
// lookup: one slot compared per cycle by a single 32-bit comparator, result
//   registered on the first matching slot, or after the last slot is compared
// one item in flight; a new beat is taken once the result register is free
// reset (synchronous, active low) clears write pointer, slot valid flags,
//   sequencer and result valid; unwritten slots read as id zero, flag zero
module message_id_dedup_ring_unit import mdr_pkg::*; #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] message_id, [32] server_flag_in, [39:33] zero
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] match_found, [5:1] slot_index, [6] server_hit, [7] zero
);

  localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  mem_ctl_t          ctl;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;
  logic [ID_W-1:0]   wr_id;
  logic              wr_flag;
  logic [ID_W-1:0]   rd_id;
  logic              rd_flag;
  logic              match_found;
  logic [SLOT_W-1:0] slot_index;
  logic              server_hit;

  mdr_seq #(
    .RING_DEPTH(RING_DEPTH),
    .IDX_W     (IDX_W)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .req_type   (in_tuser),
    .message_id (in_tdata[31:0]),
    .server_flag(in_tdata[32]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .match_found(match_found),
    .slot_index (slot_index),
    .server_hit (server_hit),
    .ctl        (ctl),
    .wr_addr    (wr_addr),
    .wr_id      (wr_id),
    .wr_flag    (wr_flag),
    .rd_addr    (rd_addr),
    .rd_id      (rd_id),
    .rd_flag    (rd_flag)
  );

  mdr_store #(
    .RING_DEPTH(RING_DEPTH),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .wr_addr(wr_addr),
    .wr_id  (wr_id),
    .wr_flag(wr_flag),
    .rd_addr(rd_addr),
    .rd_id  (rd_id),
    .rd_flag(rd_flag)
  );

  assign out_tdata = {1'b0, server_hit, slot_index, match_found};

endmodule
